// ===== rtl/core/wezs_pkg.sv =====
// Shared constants, types and register codes for the windowed energy zero suppression block.
`timescale 1ns / 1ps

package wezs_pkg;

    // Frame storage geometry.
    localparam int MAX_FRAME = 10;
    localparam int IDX_W     = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    // Field widths.
    localparam int CHAN_W  = 32;
    localparam int ADC_W   = 7;
    localparam int EXTRA_W = 9;
    localparam int PED_W   = 16;
    localparam int SUM_W   = 11;
    localparam int THR_W   = 12;
    localparam int FS_W    = 4;
    localparam int WC_W    = 4;

    // Window position compare width, one bit above the wider operand.
    localparam int WIN_W = ((CNT_W > FS_W) ? CNT_W : FS_W) + 1;

    // Pedestal product and energy arithmetic.
    localparam int PROD_W     = PED_W + CNT_W + 1;
    localparam int ENERGY_W   = 14;
    localparam int FRAC_BITS  = 8;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int TRUNC_ADJ  = (1 << FRAC_BITS) - 1;

    // Two frame banks: one being filled while the other drains.
    localparam int NUM_BANKS = 2;

    // Kept frame descriptor queue.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD    = 2'd0,
        REG_FIRST_SAMPLE = 2'd1,
        REG_WINDOW_COUNT = 2'd2,
        REG_TWO_SIDED    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [FS_W-1:0]  first_sample;
        logic [WC_W-1:0]  window_count;
        logic             two_sided;
    } cfg_t;

    typedef struct packed {
        logic [EXTRA_W-1:0] extra;
        logic [ADC_W-1:0]   adc;
    } sample_t;

    typedef struct packed {
        logic             valid;
        logic             bank;
        logic [IDX_W-1:0] idx;
        sample_t          data;
    } buf_wr_t;

    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  len;
        logic [CHAN_W-1:0] channel;
    } desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

// ===== rtl/core/window_energy_zero_suppress.sv =====
// Top level: frame zero suppression by a windowed, pedestal-corrected ADC sum.
// Samples are accepted one per cycle while the bank to fill is free; with two banks,
// input stalls only when the bank to fill still holds a kept frame that has not fully drained.
// A kept frame's first item passes the decision stage, descriptor queue and output register,
// then one item per cycle unless m_ready holds it, set by the single read port of the sample buffer.
// Synchronous active-low reset clears control state and loads register defaults.
`timescale 1ns / 1ps

module window_energy_zero_suppress (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wezs_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [wezs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [wezs_pkg::CHAN_W-1:0]       s_channel_id,
    input  logic [wezs_pkg::ADC_W-1:0]        s_adc,
    input  logic [wezs_pkg::EXTRA_W-1:0]      s_sample_extra,
    input  logic signed [wezs_pkg::PED_W-1:0] s_pedestal_adc,
    input  logic                              s_frame_first,
    input  logic                              s_frame_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [wezs_pkg::CHAN_W-1:0]       m_kept_channel_id,
    output logic [wezs_pkg::ADC_W-1:0]        m_kept_adc,
    output logic [wezs_pkg::EXTRA_W-1:0]      m_kept_extra,
    output logic                              m_last_of_run
);

    wezs_pkg::cfg_t      cfg_reg, cfg_next;
    wezs_pkg::buf_wr_t   buf_wr;
    wezs_pkg::desc_t     q_desc, head_desc;
    wezs_pkg::bank_rel_t rel;
    wezs_pkg::sample_t   rd_data;
    logic                q_push, pop, head_valid, rd_bank;
    logic [wezs_pkg::IDX_W-1:0] rd_idx;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (wezs_pkg::cfg_reg_t'(cfg_addr))
                wezs_pkg::REG_THRESHOLD: begin
                    cfg_next.threshold = cfg_wdata[wezs_pkg::THR_W-1:0];
                end
                wezs_pkg::REG_FIRST_SAMPLE: begin
                    cfg_next.first_sample = cfg_wdata[wezs_pkg::FS_W-1:0];
                end
                wezs_pkg::REG_WINDOW_COUNT: begin
                    cfg_next.window_count = cfg_wdata[wezs_pkg::WC_W-1:0];
                end
                wezs_pkg::REG_TWO_SIDED: begin
                    cfg_next.two_sided = cfg_wdata[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold    <= '0;
            cfg_reg.first_sample <= '0;
            cfg_reg.window_count <= wezs_pkg::WC_W'(4);
            cfg_reg.two_sided    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    wezs_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel_id   (s_channel_id),
        .s_adc          (s_adc),
        .s_sample_extra (s_sample_extra),
        .s_pedestal_adc (s_pedestal_adc),
        .s_frame_first  (s_frame_first),
        .s_frame_last   (s_frame_last),
        .buf_wr         (buf_wr),
        .q_push         (q_push),
        .q_desc         (q_desc),
        .rel            (rel)
    );

    wezs_sample_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd_bank (rd_bank),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    wezs_desc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    wezs_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_desc         (head_desc),
        .pop               (pop),
        .rd_bank           (rd_bank),
        .rd_idx            (rd_idx),
        .rd_data           (rd_data),
        .rel               (rel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kept_channel_id (m_kept_channel_id),
        .m_kept_adc        (m_kept_adc),
        .m_kept_extra      (m_kept_extra),
        .m_last_of_run     (m_last_of_run)
    );

endmodule

// ===== rtl/core/wezs_sample_buf.sv =====
// Two banks of frame sample storage, one write port and one read port.
`timescale 1ns / 1ps

module wezs_sample_buf (
    input  logic                      aclk,
    input  wezs_pkg::buf_wr_t         wr,
    input  logic                      rd_bank,
    input  logic [wezs_pkg::IDX_W-1:0] rd_idx,
    output wezs_pkg::sample_t         rd_data
);

    wezs_pkg::sample_t store_reg [wezs_pkg::NUM_BANKS][wezs_pkg::MAX_FRAME];

    // Sample write from the front part.
    always_ff @(posedge aclk) begin
        if (wr.valid) begin
            store_reg[wr.bank][wr.idx] <= wr.data;
        end
    end

    // Read by the back part at the sample it is emitting.
    assign rd_data = store_reg[rd_bank][rd_idx];

endmodule

// ===== rtl/core/wezs_front.sv =====
// Front part: accepts samples, buffers the frame, sums the window and decides the frame.
`timescale 1ns / 1ps

module wezs_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wezs_pkg::cfg_t                cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wezs_pkg::CHAN_W-1:0]   s_channel_id,
    input  logic [wezs_pkg::ADC_W-1:0]    s_adc,
    input  logic [wezs_pkg::EXTRA_W-1:0]  s_sample_extra,
    input  logic signed [wezs_pkg::PED_W-1:0] s_pedestal_adc,
    input  logic                          s_frame_first,
    input  logic                          s_frame_last,
    output wezs_pkg::buf_wr_t             buf_wr,
    output logic                          q_push,
    output wezs_pkg::desc_t               q_desc,
    input  wezs_pkg::bank_rel_t           rel
);

    // Frame collection state.
    logic [wezs_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [wezs_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic [wezs_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [wezs_pkg::PED_W-1:0] ped_reg, ped_next;
    logic [wezs_pkg::CHAN_W-1:0]       chan_reg, chan_next;
    logic                              wr_bank_reg, wr_bank_next;
    logic [wezs_pkg::NUM_BANKS-1:0]    busy_reg, busy_next;

    // Decision stage, loaded on the last sample of a frame.
    logic                              dec_valid_reg, dec_valid_next;
    logic [wezs_pkg::SUM_W-1:0]        dec_sum_reg;
    logic [wezs_pkg::CNT_W-1:0]        dec_cnt_reg;
    logic signed [wezs_pkg::PED_W-1:0] dec_ped_reg;
    logic [wezs_pkg::CHAN_W-1:0]       dec_chan_reg;
    logic [wezs_pkg::CNT_W-1:0]        dec_len_reg;
    logic                              dec_bank_reg;

    logic                              accept;
    logic [wezs_pkg::CNT_W-1:0]        base_idx;
    logic [wezs_pkg::SUM_W-1:0]        base_sum;
    logic [wezs_pkg::CNT_W-1:0]        base_cnt;
    logic                              in_frame;
    logic                              in_win;
    logic [wezs_pkg::WIN_W-1:0]        pos_x, fs_x, wc_x;
    logic [wezs_pkg::CNT_W-1:0]        upd_idx;
    logic [wezs_pkg::SUM_W-1:0]        upd_sum;
    logic [wezs_pkg::CNT_W-1:0]        upd_cnt;

    logic signed [wezs_pkg::PROD_W-1:0]   prod, prod_rnd, prod_adj;
    logic signed [wezs_pkg::ENERGY_W-1:0] rounded, energy, thr_s;
    logic                                 kept;

    // The front stalls while the bank it would fill still holds a frame.
    assign s_ready = !busy_reg[wr_bank_reg];
    assign accept  = s_valid && s_ready;

    // Sample position, window membership and running sums for this item.
    always_comb begin
        base_idx = s_frame_first ? '0 : idx_reg;
        base_sum = s_frame_first ? '0 : sum_reg;
        base_cnt = s_frame_first ? '0 : cnt_reg;
        ped_next  = (accept && s_frame_first) ? s_pedestal_adc : ped_reg;
        chan_next = (accept && s_frame_first) ? s_channel_id : chan_reg;

        in_frame = base_idx < wezs_pkg::CNT_W'(wezs_pkg::MAX_FRAME);
        pos_x    = wezs_pkg::WIN_W'(base_idx);
        fs_x     = wezs_pkg::WIN_W'(cfg.first_sample);
        wc_x     = wezs_pkg::WIN_W'(cfg.window_count);
        in_win   = in_frame && (pos_x >= fs_x) && ((pos_x - fs_x) < wc_x);

        upd_idx = in_frame ? base_idx + wezs_pkg::CNT_W'(1) : base_idx;
        upd_sum = in_win ? base_sum + wezs_pkg::SUM_W'(s_adc) : base_sum;
        upd_cnt = in_win ? base_cnt + wezs_pkg::CNT_W'(1) : base_cnt;

        buf_wr.valid     = accept && in_frame;
        buf_wr.bank      = wr_bank_reg;
        buf_wr.idx       = base_idx[wezs_pkg::IDX_W-1:0];
        buf_wr.data.adc   = s_adc;
        buf_wr.data.extra = s_sample_extra;
    end

    // Collection state update; a last sample hands the frame to the decision stage.
    always_comb begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        wr_bank_next   = wr_bank_reg;
        dec_valid_next = 1'b0;
        if (accept) begin
            if (s_frame_last) begin
                idx_next       = '0;
                sum_next       = '0;
                cnt_next       = '0;
                wr_bank_next   = !wr_bank_reg;
                dec_valid_next = 1'b1;
            end else begin
                idx_next = upd_idx;
                sum_next = upd_sum;
                cnt_next = upd_cnt;
            end
        end
    end

    // Energy after pedestal subtraction, rounded half up and truncated toward zero.
    always_comb begin
        prod     = wezs_pkg::PROD_W'(signed'({1'b0, dec_cnt_reg}))
                   * wezs_pkg::PROD_W'(dec_ped_reg);
        prod_rnd = prod + wezs_pkg::PROD_W'(wezs_pkg::ROUND_HALF);
        prod_adj = (prod_rnd < 0) ? prod_rnd + wezs_pkg::PROD_W'(wezs_pkg::TRUNC_ADJ)
                                  : prod_rnd;
        rounded  = wezs_pkg::ENERGY_W'(prod_adj >>> wezs_pkg::FRAC_BITS);
        energy   = $signed({{(wezs_pkg::ENERGY_W - wezs_pkg::SUM_W){1'b0}}, dec_sum_reg})
                   - rounded;
        thr_s    = $signed({{(wezs_pkg::ENERGY_W - wezs_pkg::THR_W){1'b0}}, cfg.threshold});
        kept     = (energy >= thr_s) || (cfg.two_sided && (energy <= -thr_s));
    end

    assign q_push         = dec_valid_reg && kept;
    assign q_desc.bank    = dec_bank_reg;
    assign q_desc.len     = dec_len_reg;
    assign q_desc.channel = dec_chan_reg;

    // Bank ownership: set when a frame closes, cleared on a drop or when drained.
    always_comb begin
        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (dec_valid_reg && !kept) begin
            busy_next[dec_bank_reg] = 1'b0;
        end
        if (accept && s_frame_last) begin
            busy_next[wr_bank_reg] = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            ped_reg       <= '0;
            chan_reg      <= '0;
            wr_bank_reg   <= 1'b0;
            busy_reg      <= '0;
            dec_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ped_reg       <= ped_next;
            chan_reg      <= chan_next;
            wr_bank_reg   <= wr_bank_next;
            busy_reg      <= busy_next;
            dec_valid_reg <= dec_valid_next;
        end
    end

    // Decision stage payload.
    always_ff @(posedge aclk) begin
        if (accept && s_frame_last) begin
            dec_sum_reg  <= upd_sum;
            dec_cnt_reg  <= upd_cnt;
            dec_ped_reg  <= ped_next;
            dec_chan_reg <= chan_next;
            dec_len_reg  <= upd_idx;
            dec_bank_reg <= wr_bank_reg;
        end
    end

endmodule

// ===== rtl/core/wezs_desc_queue.sv =====
// Short queue of kept frame descriptors between the front and back parts.
`timescale 1ns / 1ps

module wezs_desc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wezs_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            head_valid,
    output wezs_pkg::desc_t head_desc
);

    wezs_pkg::desc_t              entry_reg [wezs_pkg::Q_DEPTH];
    logic [wezs_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [wezs_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [wezs_pkg::Q_PTR_W:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update; never more frames than banks are in flight.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == wezs_pkg::Q_PTR_W'(wezs_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + wezs_pkg::Q_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == wezs_pkg::Q_PTR_W'(wezs_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + wezs_pkg::Q_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (wezs_pkg::Q_PTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (wezs_pkg::Q_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/core/wezs_back.sv =====
// Back part: drains kept frames from the sample buffer into the output register.
`timescale 1ns / 1ps

module wezs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  wezs_pkg::desc_t               head_desc,
    output logic                          pop,
    output logic                          rd_bank,
    output logic [wezs_pkg::IDX_W-1:0]    rd_idx,
    input  wezs_pkg::sample_t             rd_data,
    output wezs_pkg::bank_rel_t           rel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wezs_pkg::CHAN_W-1:0]   m_kept_channel_id,
    output logic [wezs_pkg::ADC_W-1:0]    m_kept_adc,
    output logic [wezs_pkg::EXTRA_W-1:0]  m_kept_extra,
    output logic                          m_last_of_run
);

    logic [wezs_pkg::IDX_W-1:0]   k_reg, k_next;
    logic                         m_valid_reg, m_valid_next;
    logic [wezs_pkg::CHAN_W-1:0]  m_chan_reg;
    logic [wezs_pkg::ADC_W-1:0]   m_adc_reg;
    logic [wezs_pkg::EXTRA_W-1:0] m_extra_reg;
    logic                         m_last_reg;
    logic                         load;
    logic                         is_last;

    // Read the sample at the current position of the frame at the queue head.
    assign rd_bank = head_desc.bank;
    assign rd_idx  = k_reg;

    // A queued sample loads whenever the output register is empty or being taken.
    always_comb begin
        load    = head_valid && (!m_valid_reg || m_ready);
        is_last = (wezs_pkg::CNT_W'(k_reg) + wezs_pkg::CNT_W'(1)) == head_desc.len;
        pop       = load && is_last;
        rel.valid = pop;
        rel.bank  = head_desc.bank;

        k_next = k_reg;
        if (load) begin
            k_next = is_last ? '0 : k_reg + wezs_pkg::IDX_W'(1);
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (load) begin
            m_chan_reg  <= head_desc.channel;
            m_adc_reg   <= rd_data.adc;
            m_extra_reg <= rd_data.extra;
            m_last_reg  <= is_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kept_channel_id = m_chan_reg;
    assign m_kept_adc        = m_adc_reg;
    assign m_kept_extra      = m_extra_reg;
    assign m_last_of_run     = m_last_reg;

endmodule

// ===== tb/sv/zs_frame_checker.sv =====
// Checker for the windowed energy zero suppression block: follows both channels, predicts, compares.
`timescale 1ns / 1ps

module zs_frame_checker
    import wezs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [CHAN_W-1:0]       s_channel_id,
    input  logic [ADC_W-1:0]        s_adc,
    input  logic [EXTRA_W-1:0]      s_sample_extra,
    input  logic signed [PED_W-1:0] s_pedestal_adc,
    input  logic                    s_frame_first,
    input  logic                    s_frame_last,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [CHAN_W-1:0]       m_kept_channel_id,
    input  logic [ADC_W-1:0]        m_kept_adc,
    input  logic [EXTRA_W-1:0]      m_kept_extra,
    input  logic                    m_last_of_run,
    output int                      mismatch_count,
    output int                      kept_pending
);

    // Register values after reset.
    localparam logic [THR_W-1:0] THRESHOLD_RESET    = '0;
    localparam logic [FS_W-1:0]  FIRST_SAMPLE_RESET = '0;
    localparam logic [WC_W-1:0]  WINDOW_COUNT_RESET = 4'd4;
    localparam int               MAX_PRINTED        = 40;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [ADC_W-1:0]   adc;
        logic [EXTRA_W-1:0] extra;
        logic               last;
    } kept_sample_t;

    // Samples of kept frames still to come out, oldest first.
    kept_sample_t kept_samples_q[$];

    // Predictor state.
    cfg_t                    cfg;
    sample_t                 frame_samples [MAX_FRAME];
    int                      next_pos;
    logic [SUM_W-1:0]        window_sum;
    logic [3:0]              window_n;
    logic signed [PED_W-1:0] frame_ped;
    logic [CHAN_W-1:0]       frame_chan;

    task automatic report_mismatch(input string what, input logic [CHAN_W-1:0] got,
                                   input logic [CHAN_W-1:0] want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Pedestal-corrected window energy against the threshold; division truncates toward zero.
    function automatic bit frame_energy_passes();
        int rounded;
        int energy;
        int thr;
        rounded = (int'(window_n) * int'(frame_ped) + ROUND_HALF) / (1 << FRAC_BITS);
        energy  = int'(window_sum) - rounded;
        thr     = int'(cfg.threshold);
        return (energy >= thr) || (cfg.two_sided && energy <= -thr);
    endfunction

    // Take one accepted item into the frame and queue the kept frame on its last sample.
    task automatic absorb_sample();
        int first_pos;
        kept_sample_t k;
        first_pos = int'(cfg.first_sample);
        if (s_frame_first) begin
            next_pos   = 0;
            window_sum = '0;
            window_n   = '0;
            frame_ped  = s_pedestal_adc;
            frame_chan = s_channel_id;
        end
        if (next_pos < MAX_FRAME) begin
            frame_samples[next_pos] = '{extra: s_sample_extra, adc: s_adc};
            if (next_pos >= first_pos && next_pos - first_pos < int'(cfg.window_count)) begin
                window_sum = window_sum + SUM_W'(s_adc);
                window_n   = window_n + 4'd1;
            end
            next_pos++;
        end
        if (s_frame_last) begin
            if (frame_energy_passes()) begin
                for (int i = 0; i < next_pos; i++) begin
                    k.chan  = frame_chan;
                    k.adc   = frame_samples[i].adc;
                    k.extra = frame_samples[i].extra;
                    k.last  = (i + 1 == next_pos);
                    kept_samples_q = {kept_samples_q, k};
                end
            end
            next_pos   = 0;
            window_sum = '0;
            window_n   = '0;
        end
    endtask

    // Everything is sampled at the rising edge, before the block's outputs move.
    always @(posedge aclk) begin
        kept_sample_t want;
        if (!aresetn) begin
            cfg.threshold    = THRESHOLD_RESET;
            cfg.first_sample = FIRST_SAMPLE_RESET;
            cfg.window_count = WINDOW_COUNT_RESET;
            cfg.two_sided    = 1'b0;
            next_pos         = 0;
            window_sum       = '0;
            window_n         = '0;
            frame_ped        = '0;
            frame_chan       = '0;
            mismatch_count   = 0;
            kept_samples_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_THRESHOLD:    cfg.threshold    = cfg_wdata[THR_W-1:0];
                    REG_FIRST_SAMPLE: cfg.first_sample = cfg_wdata[FS_W-1:0];
                    REG_WINDOW_COUNT: cfg.window_count = cfg_wdata[WC_W-1:0];
                    REG_TWO_SIDED:    cfg.two_sided    = cfg_wdata[0];
                    default: ;
                endcase
            end

            // Compare each result item with the oldest expectation.
            if (m_valid && m_ready) begin
                if (kept_samples_q.size() == 0) begin
                    report_mismatch("item with nothing expected", m_kept_channel_id, '0);
                end else begin
                    want = kept_samples_q.pop_front();
                    if (m_kept_channel_id !== want.chan)
                        report_mismatch("kept_channel_id", m_kept_channel_id, want.chan);
                    if (m_kept_adc !== want.adc)
                        report_mismatch("kept_adc", CHAN_W'(m_kept_adc), CHAN_W'(want.adc));
                    if (m_kept_extra !== want.extra)
                        report_mismatch("kept_extra", CHAN_W'(m_kept_extra),
                                        CHAN_W'(want.extra));
                    if (m_last_of_run !== want.last)
                        report_mismatch("last_of_run", CHAN_W'(m_last_of_run),
                                        CHAN_W'(want.last));
                end
            end

            if (s_valid && s_ready) begin
                absorb_sample();
            end
        end
        kept_pending = kept_samples_q.size();
    end

endmodule

// ===== tb/sv/window_energy_zero_suppress_tb.sv =====
// Testbench top: clock, reset, register setup and item traffic for the zero suppression block.
`timescale 1ns / 1ps

module window_energy_zero_suppress_tb;
    import wezs_pkg::*;

    // Cycles allowed after the last expected item before registers change or the run ends.
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 80;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [CHAN_W-1:0]       s_channel_id;
    logic [ADC_W-1:0]        s_adc;
    logic [EXTRA_W-1:0]      s_sample_extra;
    logic signed [PED_W-1:0] s_pedestal_adc;
    logic                    s_frame_first;
    logic                    s_frame_last;
    logic                    m_valid;
    logic                    m_ready;
    logic [CHAN_W-1:0]       m_kept_channel_id;
    logic [ADC_W-1:0]        m_kept_adc;
    logic [EXTRA_W-1:0]      m_kept_extra;
    logic                    m_last_of_run;

    int mismatch_count;
    int kept_pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_done;

    window_energy_zero_suppress dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_channel_id      (s_channel_id),
        .s_adc             (s_adc),
        .s_sample_extra    (s_sample_extra),
        .s_pedestal_adc    (s_pedestal_adc),
        .s_frame_first     (s_frame_first),
        .s_frame_last      (s_frame_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kept_channel_id (m_kept_channel_id),
        .m_kept_adc        (m_kept_adc),
        .m_kept_extra      (m_kept_extra),
        .m_last_of_run     (m_last_of_run)
    );

    zs_frame_checker frame_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_channel_id      (s_channel_id),
        .s_adc             (s_adc),
        .s_sample_extra    (s_sample_extra),
        .s_pedestal_adc    (s_pedestal_adc),
        .s_frame_first     (s_frame_first),
        .s_frame_last      (s_frame_last),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kept_channel_id (m_kept_channel_id),
        .m_kept_adc        (m_kept_adc),
        .m_kept_extra      (m_kept_extra),
        .m_last_of_run     (m_last_of_run),
        .mismatch_count    (mismatch_count),
        .kept_pending      (kept_pending)
    );

    // 2 ns clock.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Result side: random stalls, plus a long hold whenever one is requested.
    initial begin
        m_ready    = 1'b0;
        holds_done = 0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, with random idle cycles ahead of it, and wait until it is taken.
    task automatic offer(input logic [CHAN_W-1:0] chan, input logic [ADC_W-1:0] adc,
                         input logic [EXTRA_W-1:0] extra, input logic [PED_W-1:0] ped,
                         input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_channel_id   = chan;
        s_adc          = adc;
        s_sample_extra = extra;
        s_pedestal_adc = ped;
        s_frame_first  = first;
        s_frame_last   = last;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = r;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic configure(input int thr, input int first_pos, input int count,
                             input bit both_signs);
        set_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        set_reg(REG_FIRST_SAMPLE, CFG_DATA_W'(first_pos));
        set_reg(REG_WINDOW_COUNT, CFG_DATA_W'(count));
        set_reg(REG_TWO_SIDED, CFG_DATA_W'(both_signs));
    endtask

    // Stop offering until every kept item is out and a dropped frame has had time to settle.
    task automatic drain_results();
        s_valid = 1'b0;
        wait (kept_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly small pedestals around the typical ADC level; a quarter span the whole Q8.8 range.
    function automatic logic [PED_W-1:0] pick_pedestal();
        if ($urandom_range(3) == 0) begin
            return PED_W'($urandom);
        end
        return PED_W'(int'($urandom_range(6000)) - 1500);
    endfunction

    // One random frame: mostly well formed, some continuing the previous frame,
    // some abandoned without a last mark. A closing frame is always well formed.
    task automatic send_random_frame(input bit closing);
        int kind;
        int len;
        bit saturate;
        bit has_first;
        bit has_last;
        logic [CHAN_W-1:0] chan;
        logic [PED_W-1:0] ped;
        kind      = closing ? 0 : $urandom_range(99);
        has_first = (kind < 80) || (kind >= 90);
        has_last  = (kind < 90);
        chan      = $urandom;
        ped       = pick_pedestal();
        saturate  = ($urandom_range(7) == 0);
        len       = ($urandom_range(9) == 0) ? $urandom_range(MAX_FRAME + 1, MAX_FRAME + 4)
                                              : $urandom_range(1, MAX_FRAME);
        for (int i = 0; i < len; i++) begin
            offer(chan, saturate ? {ADC_W{1'b1}} : ADC_W'($urandom), EXTRA_W'($urandom), ped,
                  has_first && (i == 0), has_last && (i == len - 1));
        end
    endtask

    task automatic run_phase(input int thr, input int first_pos, input int count,
                             input bit both_signs, input int idle_pct, input int stall_pct,
                             input int frames);
        drain_results();
        configure(thr, first_pos, count, both_signs);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int f = 0; f < frames; f++) begin
            send_random_frame(f == frames - 1);
        end
    endtask

    // Run-time limit.
    initial begin
        #400000;
        $display("[window_energy_zero_suppress] ERROR");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_channel_id   = '0;
        s_adc          = '0;
        s_sample_extra = '0;
        s_pedestal_adc = '0;
        s_frame_first  = 1'b0;
        s_frame_last   = 1'b0;
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        hold_requests  = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed items under the reset register values.
        // Single-sample frames: full-scale negative pedestal, full-scale positive pedestal,
        // a pedestal just below minus one half (truncates to zero) and exactly one half.
        offer({CHAN_W{1'b1}}, {ADC_W{1'b1}}, {EXTRA_W{1'b1}}, 16'h8000, 1'b1, 1'b1);
        offer('0, '0, '0, 16'h7FFF, 1'b1, 1'b1);
        offer(32'hA5A5_0F0F, '0, 9'h155, 16'hFF7F, 1'b1, 1'b1);
        offer(32'h0F0F_A5A5, '0, 9'h0AA, 16'h0080, 1'b1, 1'b1);
        // Frame longer than the buffer: extra samples are dropped, the last still decides.
        for (int i = 0; i < MAX_FRAME + 2; i++) begin
            offer(32'h0000_0001, ADC_W'(i * 10), EXTRA_W'(i * 37), 16'h0000,
                  i == 0, i == MAX_FRAME + 1);
        end
        // Samples without a frame start reuse the latched channel and pedestal.
        offer(32'h5A5A_0001, 7'h40, 9'h0F0, 16'h7FFF, 1'b0, 1'b0);
        offer(32'h5A5A_0002, 7'h41, 9'h10F, 16'h7FFF, 1'b0, 1'b1);
        // A frame restarted before its last sample.
        offer(32'h1234_5678, 7'h11, 9'h100, 16'hFF00, 1'b1, 1'b0);
        offer(32'h1234_5679, 7'h12, 9'h001, 16'hFF00, 1'b0, 1'b0);
        offer(32'h8765_4321, 7'h22, 9'h055, 16'h0100, 1'b1, 1'b1);

        // Random frames over a spread of register settings and idle patterns.
        // The block is filled against a long receiver hold in the first phase.
        drain_results();
        configure(0, 0, MAX_FRAME, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_frame(1'b1);
        hold_requests++;
        for (int f = 0; f < 6; f++) begin
            send_random_frame(f == 5);
        end

        // Sender waits for every kept item halfway through this phase.
        drain_results();
        configure(20, 2, 4, 1'b1);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        for (int f = 0; f < 3; f++) begin
            send_random_frame(f == 2);
        end
        s_valid = 1'b0;
        wait (kept_pending == 0);
        @(negedge aclk);
        for (int f = 0; f < 3; f++) begin
            send_random_frame(f == 2);
        end

        run_phase(300, 0, MAX_FRAME, 1'b0, 0, 83, 4);
        run_phase(4095, MAX_FRAME - 1, 0, 1'b1, 30, 30, 3);
        run_phase(4095, MAX_FRAME - 1, MAX_FRAME, 1'b0, 0, 0, 3);
        run_phase(3, MAX_FRAME - 1, 1, 1'b1, 30, 30, 4);
        run_phase($urandom_range(400), $urandom_range(MAX_FRAME - 1), $urandom_range(MAX_FRAME),
                  1'($urandom), 0, 83, 3);
        run_phase(0, 5, 3, 1'b1, 30, 30, 3);

        drain_results();
        if (mismatch_count == 0) begin
            $display("[window_energy_zero_suppress] OK");
        end else begin
            $display("[window_energy_zero_suppress] ERROR");
        end
        $finish;
    end

endmodule
